FILE: src/bti_pkg.sv
package bti_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int ROW_AW     = 4;
    localparam int COL_AW     = 4;
    localparam int TAB_AW     = ROW_AW + COL_AW;
    localparam int TAB_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_POINTS = 2;

    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DATA_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

    localparam logic [1:0] BL_ROW_LO = 2'd0;
    localparam logic [1:0] BL_ROW_HI = 2'd1;
    localparam logic [1:0] BL_COL    = 2'd2;

    typedef enum logic [1:0] {
        FUNC_ROW_BP = 2'd0,
        FUNC_COL_BP = 2'd1,
        FUNC_TAB    = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_FEW = 2'd1,
        ST_OOB = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_READ,
        S_SETUP,
        S_STEP,
        S_END,
        S_DONE
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [ROW_AW-1:0]  row_index;
        logic [COL_AW-1:0]  col_index;
        logic signed [31:0] data;
        logic signed [31:0] row_key;
        logic signed [31:0] col_key;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        logic              take;
        logic              start;
        logic              scan;
        logic              rd;
        logic              setup;
        logic              step;
        logic              fin;
        logic [1:0]        bl_sel;
        logic [CNT_W-1:0]  cnt;
        logic              load_out;
        status_t           out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic few;
        logic oob;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [DATA_W-1:0] prev;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] last;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [ROW_AW-1:0] idx;
        logic              found;
    } axis_t;

endpackage

FILE: src/bti_ram.sv
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bti_ctrl.sv
module bti_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bti_pkg::func_t     in_func,
    output logic               in_ready,
    input  bti_pkg::dp_stat_t  stat,
    output bti_pkg::ctrl_cmd_t cmd,
    output bti_pkg::state_t    state
);

    bti_pkg::state_t               state_reg, state_next;
    logic [bti_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                    bl_reg, bl_next;
    bti_pkg::status_t              st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bti_pkg::S_IDLE;
            cnt_reg   <= '0;
            bl_reg    <= bti_pkg::BL_ROW_LO;
            st_reg    <= bti_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bl_reg    <= bl_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bl_next    = bl_reg;
        st_next    = st_reg;
        unique case (state_reg)
            bti_pkg::S_IDLE:
            begin
                if (in_valid && in_func == bti_pkg::FUNC_QUERY)
                begin
                    cnt_next = '0;
                    if (stat.few)
                    begin
                        st_next    = bti_pkg::ST_FEW;
                        state_next = bti_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bti_pkg::S_SCAN;
                    end
                end
            end
            bti_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bti_pkg::SCAN_LAST)
                begin
                    state_next = bti_pkg::S_CHECK;
                end
            end
            bti_pkg::S_CHECK:
            begin
                cnt_next = '0;
                if (stat.oob)
                begin
                    st_next    = bti_pkg::ST_OOB;
                    state_next = bti_pkg::S_DONE;
                end
                else
                begin
                    state_next = bti_pkg::S_READ;
                end
            end
            bti_pkg::S_READ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bti_pkg::READ_LAST)
                begin
                    bl_next    = bti_pkg::BL_ROW_LO;
                    state_next = bti_pkg::S_SETUP;
                end
            end
            bti_pkg::S_SETUP:
            begin
                cnt_next   = '0;
                state_next = bti_pkg::S_STEP;
            end
            bti_pkg::S_STEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bti_pkg::STEP_LAST)
                begin
                    state_next = bti_pkg::S_END;
                end
            end
            bti_pkg::S_END:
            begin
                if (bl_reg == bti_pkg::BL_COL)
                begin
                    st_next    = bti_pkg::ST_OK;
                    state_next = bti_pkg::S_DONE;
                end
                else
                begin
                    bl_next    = bl_reg + 1'b1;
                    state_next = bti_pkg::S_SETUP;
                end
            end
            bti_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = bti_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bti_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == bti_pkg::S_IDLE);
        cmd            = '0;
        cmd.take       = in_ready && in_valid;
        cmd.start      = in_ready && in_valid && in_func == bti_pkg::FUNC_QUERY;
        cmd.scan       = (state_reg == bti_pkg::S_SCAN);
        cmd.rd         = (state_reg == bti_pkg::S_READ);
        cmd.setup      = (state_reg == bti_pkg::S_SETUP);
        cmd.step       = (state_reg == bti_pkg::S_STEP);
        cmd.fin        = (state_reg == bti_pkg::S_END);
        cmd.bl_sel     = bl_reg;
        cmd.cnt        = cnt_reg;
        cmd.load_out   = (state_reg == bti_pkg::S_DONE) && stat.out_free;
        cmd.out_status = st_reg;
    end

    assign state = state_reg;

endmodule

FILE: src/bti_dp.sv
module bti_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bti_pkg::in_item_t                  in_item,
    input  bti_pkg::ctrl_cmd_t                 cmd,
    output bti_pkg::dp_stat_t                  stat,
    input  logic                               cfg_valid,
    input  logic [bti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bti_pkg::out_item_t                 out_item
);

    function automatic bti_pkg::axis_t axis_update(
        input bti_pkg::axis_t                a,
        input logic [bti_pkg::DATA_W-1:0]    cur,
        input logic [bti_pkg::ROW_AW-1:0]    p,
        input logic [bti_pkg::CNT_W-1:0]     n,
        input logic signed [31:0]            key
    );
        bti_pkg::axis_t b;
        logic           hit;
        b   = a;
        hit = (key >= $signed(a.prev)) && (key <= $signed(cur));
        if (p == '0)
        begin
            b.first = cur;
        end
        if ({1'b0, p} < n)
        begin
            if (p == bti_pkg::ROW_AW'(1))
            begin
                b.lo    = a.prev;
                b.hi    = cur;
                b.idx   = '0;
                b.found = hit;
            end
            else if (p != '0 && !a.found && hit)
            begin
                b.lo    = a.prev;
                b.hi    = cur;
                b.idx   = p - 1'b1;
                b.found = 1'b1;
            end
            if ({1'b0, p} == n - 1'b1)
            begin
                b.last = cur;
            end
        end
        b.prev = cur;
        return b;
    endfunction

    logic [bti_pkg::CNT_W-1:0]  row_count_reg, col_count_reg;
    logic [bti_pkg::CNT_W-1:0]  nr, nc;
    logic signed [31:0]         rk_reg, ck_reg;
    bti_pkg::axis_t             row_ax_reg, col_ax_reg;
    logic [bti_pkg::DATA_W-1:0] row_rdata, col_rdata, tab_rdata;
    logic [bti_pkg::TAB_AW-1:0] tab_raddr;
    logic [bti_pkg::ROW_AW-1:0] scan_p, r1;
    logic [bti_pkg::COL_AW-1:0] c1;
    logic [bti_pkg::DATA_W-1:0] v_reg [4];
    logic signed [31:0]         h0_reg, h1_reg, res_reg;

    logic signed [31:0]         vlo, vhi, klo, khi, key;
    logic signed [32:0]         span_w, off_w, diff_w, ndiff_w;
    logic [31:0]                off_c;
    logic [31:0]                span_reg, off_reg, dmag_reg, rem_reg, q_reg;
    logic                       neg_reg, pos_reg;
    logic signed [31:0]         vlo_reg;
    logic [33:0]                r2, two_span, span34;
    logic [31:0]                rem_next, q_next;
    logic signed [32:0]         sum_w;
    logic signed [31:0]         blend_res;

    logic                       out_valid_reg;
    bti_pkg::out_item_t         out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            priority if (cfg_index == bti_pkg::CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[bti_pkg::CNT_W-1:0];
            end
            else if (cfg_index == bti_pkg::CFG_COL_COUNT)
            begin
                col_count_reg <= cfg_data[bti_pkg::CNT_W-1:0];
            end
        end
    end

    assign nr = (row_count_reg > bti_pkg::CNT_W'(bti_pkg::MAX_ROWS)) ?
                bti_pkg::CNT_W'(bti_pkg::MAX_ROWS) : row_count_reg;
    assign nc = (col_count_reg > bti_pkg::CNT_W'(bti_pkg::MAX_COLS)) ?
                bti_pkg::CNT_W'(bti_pkg::MAX_COLS) : col_count_reg;

    bti_ram #(.WIDTH(bti_pkg::DATA_W), .DEPTH(bti_pkg::MAX_ROWS)) u_row_ram (
        .clk   (clk),
        .we    (cmd.take && in_item.func == bti_pkg::FUNC_ROW_BP),
        .waddr (in_item.row_index),
        .wdata (in_item.data),
        .raddr (cmd.cnt[bti_pkg::ROW_AW-1:0]),
        .rdata (row_rdata)
    );

    bti_ram #(.WIDTH(bti_pkg::DATA_W), .DEPTH(bti_pkg::MAX_COLS)) u_col_ram (
        .clk   (clk),
        .we    (cmd.take && in_item.func == bti_pkg::FUNC_COL_BP),
        .waddr (in_item.col_index),
        .wdata (in_item.data),
        .raddr (cmd.cnt[bti_pkg::COL_AW-1:0]),
        .rdata (col_rdata)
    );

    assign r1 = row_ax_reg.idx + 1'b1;
    assign c1 = col_ax_reg.idx + 1'b1;

    always_comb
    begin
        unique case (cmd.cnt[1:0])
            2'd0:    tab_raddr = {row_ax_reg.idx, col_ax_reg.idx};
            2'd1:    tab_raddr = {r1, col_ax_reg.idx};
            2'd2:    tab_raddr = {row_ax_reg.idx, c1};
            default: tab_raddr = {r1, c1};
        endcase
    end

    bti_ram #(.WIDTH(bti_pkg::DATA_W), .DEPTH(bti_pkg::TAB_DEPTH)) u_tab_ram (
        .clk   (clk),
        .we    (cmd.take && in_item.func == bti_pkg::FUNC_TAB),
        .waddr ({in_item.row_index, in_item.col_index}),
        .wdata (in_item.data),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    assign scan_p = bti_pkg::ROW_AW'(cmd.cnt - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rk_reg <= in_item.row_key;
            ck_reg <= in_item.col_key;
        end
        if (cmd.scan && cmd.cnt != '0)
        begin
            row_ax_reg <= axis_update(row_ax_reg, row_rdata, scan_p, nr, rk_reg);
            col_ax_reg <= axis_update(col_ax_reg, col_rdata, scan_p, nc, ck_reg);
        end
        if (cmd.rd && cmd.cnt != '0)
        begin
            v_reg[2'(cmd.cnt - 1'b1)] <= tab_rdata;
        end
    end

    assign stat.few = (nr < bti_pkg::CNT_W'(bti_pkg::MIN_POINTS)) ||
                      (nc < bti_pkg::CNT_W'(bti_pkg::MIN_POINTS));
    assign stat.oob = (rk_reg < $signed(row_ax_reg.first)) ||
                      (rk_reg > $signed(row_ax_reg.last))  ||
                      (ck_reg < $signed(col_ax_reg.first)) ||
                      (ck_reg > $signed(col_ax_reg.last));

    // blend operand select
    always_comb
    begin
        unique case (cmd.bl_sel)
            bti_pkg::BL_ROW_LO:
            begin
                vlo = $signed(v_reg[0]);
                vhi = $signed(v_reg[1]);
                klo = $signed(row_ax_reg.lo);
                khi = $signed(row_ax_reg.hi);
                key = rk_reg;
            end
            bti_pkg::BL_ROW_HI:
            begin
                vlo = $signed(v_reg[2]);
                vhi = $signed(v_reg[3]);
                klo = $signed(row_ax_reg.lo);
                khi = $signed(row_ax_reg.hi);
                key = rk_reg;
            end
            default:
            begin
                vlo = h0_reg;
                vhi = h1_reg;
                klo = $signed(col_ax_reg.lo);
                khi = $signed(col_ax_reg.hi);
                key = ck_reg;
            end
        endcase
    end

    always_comb
    begin
        span_w  = {khi[31], khi} - {klo[31], klo};
        off_w   = {key[31], key} - {klo[31], klo};
        diff_w  = {vhi[31], vhi} - {vlo[31], vlo};
        ndiff_w = -diff_w;
        if (off_w < 0)
        begin
            off_c = '0;
        end
        else if (off_w > span_w)
        begin
            off_c = span_w[31:0];
        end
        else
        begin
            off_c = off_w[31:0];
        end
    end

    // one magnitude bit per cycle, remainder kept below span
    always_comb
    begin
        r2       = {1'b0, rem_reg, 1'b0} + (dmag_reg[31] ? {2'b00, off_reg} : 34'd0);
        two_span = {1'b0, span_reg, 1'b0};
        span34   = {2'b00, span_reg};
        if (r2 >= two_span)
        begin
            rem_next = 32'(r2 - two_span);
            q_next   = {q_reg[30:0], 1'b0} + 32'd2;
        end
        else if (r2 >= span34)
        begin
            rem_next = 32'(r2 - span34);
            q_next   = {q_reg[30:0], 1'b0} + 32'd1;
        end
        else
        begin
            rem_next = r2[31:0];
            q_next   = {q_reg[30:0], 1'b0};
        end
        sum_w     = neg_reg ? ({vlo_reg[31], vlo_reg} - $signed({1'b0, q_reg})) :
                              ({vlo_reg[31], vlo_reg} + $signed({1'b0, q_reg}));
        blend_res = pos_reg ? sum_w[31:0] : vlo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            span_reg <= span_w[31:0];
            off_reg  <= off_c;
            dmag_reg <= diff_w[32] ? ndiff_w[31:0] : diff_w[31:0];
            neg_reg  <= diff_w[32];
            pos_reg  <= (span_w > 0);
            vlo_reg  <= vlo;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            dmag_reg <= {dmag_reg[30:0], 1'b0};
        end
        if (cmd.fin)
        begin
            unique case (cmd.bl_sel)
                bti_pkg::BL_ROW_LO: h0_reg  <= blend_res;
                bti_pkg::BL_ROW_HI: h1_reg  <= blend_res;
                default:            res_reg <= blend_res;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_item_reg.status <= cmd.out_status;
            out_item_reg.result <= (cmd.out_status == bti_pkg::ST_OK) ? res_reg : 32'sd0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

endmodule

FILE: src/bilinear_table_interpolator_unit.sv
// Two-dimensional map with bilinear interpolation. Writes of row breakpoints,
// column breakpoints and table values return nothing. A query returns one
// item: status too-few-points, key-out-of-bounds, or an interpolated Q16.16
// value. The value comes from a scan of both breakpoint memories through
// their single read ports, four table reads, and three passes of a shared
// multiply-divide unit that handles one bit of the value difference per
// cycle. A finished item waits in an output register while new writes are
// taken. Configuration writes are always accepted.
module bilinear_table_interpolator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bti_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bti_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    bti_pkg::ctrl_cmd_t cmd;
    bti_pkg::dp_stat_t  stat;
    bti_pkg::state_t    state;

    assign cfg_ready = 1'b1;

    bti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_item.func),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    bti_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.func == bti_pkg::FUNC_QUERY) |=> !in_ready)
        else $error("input taken during query");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == bti_pkg::S_DONE))
        else $error("result item without finished query");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != bti_pkg::ST_OK) |-> (out_item.result == 32'sd0))
        else $error("nonzero result on error status");
`endif

endmodule
